// File: rtl/core/wtc_pkg.sv
// ----------------------------------------------------------------------------
// wtc_pkg
// Shared types and constants of the windowed text console.
// ----------------------------------------------------------------------------
`default_nettype none

package wtc_pkg;

	// default screen geometry
	localparam int SCREEN_COLUMNS_DEF = 80;
	localparam int SCREEN_ROWS_DEF    = 25;

	// field widths
	localparam int ACT_W  = 2;
	localparam int CHAR_W = 8;
	localparam int AIN_W  = 11;   // cell_address
	localparam int POS_W  = 11;   // cursor_position
	localparam int CELL_W = 16;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ATTR_W = 8;
	localparam int SROW_W = ROW_W + 1;   // top row plus window row
	localparam int SCOL_W = COL_W + 1;   // left column plus window column
	localparam int REG_W  = 3;
	localparam int CFGD_W = 8;

	// actions
	localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	// register indexes
	localparam logic [REG_W-1:0] REG_LEFT_A  = 3'd0;
	localparam logic [REG_W-1:0] REG_COUNT_A = 3'd1;
	localparam logic [REG_W-1:0] REG_LEFT_B  = 3'd2;
	localparam logic [REG_W-1:0] REG_COUNT_B = 3'd3;
	localparam logic [REG_W-1:0] REG_TOP     = 3'd4;
	localparam logic [REG_W-1:0] REG_ROWS    = 3'd5;
	localparam logic [REG_W-1:0] REG_ATTR_A  = 3'd6;
	localparam logic [REG_W-1:0] REG_ATTR_B  = 3'd7;

	// register reset values
	localparam logic [COL_W-1:0]  RST_LEFT_A  = 7'd0;
	localparam logic [COL_W-1:0]  RST_COUNT_A = 7'd40;
	localparam logic [COL_W-1:0]  RST_LEFT_B  = 7'd40;
	localparam logic [COL_W-1:0]  RST_COUNT_B = 7'd40;
	localparam logic [ROW_W-1:0]  RST_TOP     = 5'd0;
	localparam logic [ROW_W-1:0]  RST_ROWS    = 5'd25;
	localparam logic [ATTR_W-1:0] RST_ATTR    = 8'h0F;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [CELL_W-1:0] RESET_CELL = {RST_ATTR, CH_SPACE};

	typedef struct packed {
		logic init_write;
		logic load_item;
		logic put;
		logic clr_start;
		logic clr_write;
		logic scr_start;
		logic scr_read;
		logic scr_write;
		logic item_read;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic             init_last;
		logic [ACT_W-1:0] action;
		logic             put_scroll;
		logic             clr_last;
		logic             scr_last;
		logic             out_free;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/core/wtc_if.sv
// ----------------------------------------------------------------------------
// wtc_if
// Valid/ready channels of the windowed text console.
// ----------------------------------------------------------------------------
`default_nettype none

interface wtc_item_if;
	logic                           valid;
	logic                           ready;
	logic [wtc_pkg::ACT_W-1:0]      action;
	logic                           window_select;
	logic [wtc_pkg::CHAR_W-1:0]     char_code;
	logic [wtc_pkg::AIN_W-1:0]      cell_address;

	modport source (output valid, action, window_select, char_code, cell_address,
		input ready);
	modport sink (input valid, action, window_select, char_code, cell_address,
		output ready);
endinterface

interface wtc_result_if;
	logic                           valid;
	logic                           ready;
	logic [wtc_pkg::POS_W-1:0]      cursor_position;
	logic [wtc_pkg::CELL_W-1:0]     cell_data;

	modport source (output valid, cursor_position, cell_data, input ready);
	modport sink (input valid, cursor_position, cell_data, output ready);
endinterface

interface wtc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wtc_pkg::REG_W-1:0]      index;
	logic [wtc_pkg::CFGD_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wtc_ctrl.sv
// ----------------------------------------------------------------------------
// wtc_ctrl
// Sequencer: clearing pass, item decode, window walks and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module wtc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire wtc_pkg::stat_t stat,
	output wtc_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLR,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	// a new item may enter in the cycle that the previous result is loaded
	assign item_ready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && stat.out_free);

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		cmd.load_item = item_valid && item_ready;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_write = 1'b1;
				if (stat.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (stat.action)
					wtc_pkg::ACT_PUT: begin
						cmd.put = 1'b1;
						if (stat.put_scroll) begin
							cmd.scr_start = 1'b1;
							state_d       = ST_SCR_RD;
						end else begin
							state_d = ST_DONE;
						end
					end
					wtc_pkg::ACT_CLEAR: begin
						cmd.clr_start = 1'b1;
						state_d       = ST_CLR;
					end
					wtc_pkg::ACT_READ: begin
						cmd.item_read = 1'b1;
						state_d       = ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_CLR: begin
				cmd.clr_write = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_SCR_RD: begin
				cmd.scr_read = 1'b1;
				state_d      = ST_SCR_WR;
			end
			ST_SCR_WR: begin
				cmd.scr_write = 1'b1;
				state_d       = stat.scr_last ? ST_DONE : ST_SCR_RD;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = item_valid ? ST_EXEC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/wtc_datapath.sv
// ----------------------------------------------------------------------------
// wtc_datapath
// Screen memory, window registers, cursors, walk counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wtc_datapath #(
	parameter int SCREEN_COLUMNS = wtc_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = wtc_pkg::SCREEN_ROWS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire wtc_pkg::cmd_t                cmd,
	output wtc_pkg::stat_t                    stat,
	input  wire logic [wtc_pkg::ACT_W-1:0]    item_action,
	input  wire logic                         item_window,
	input  wire logic [wtc_pkg::CHAR_W-1:0]   item_char,
	input  wire logic [wtc_pkg::AIN_W-1:0]    item_address,
	input  wire logic                         cfg_we,
	input  wire logic [wtc_pkg::REG_W-1:0]    cfg_index,
	input  wire logic [wtc_pkg::CFGD_W-1:0]   cfg_data,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic [wtc_pkg::POS_W-1:0]         res_cursor,
	output logic [wtc_pkg::CELL_W-1:0]        res_data
);

	localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = wtc_pkg::COL_W;
	localparam int ROW_W      = wtc_pkg::ROW_W;
	localparam int SROW_W     = wtc_pkg::SROW_W;
	localparam int SCOL_W     = wtc_pkg::SCOL_W;
	localparam int CELL_W     = wtc_pkg::CELL_W;
	localparam int POS_W      = wtc_pkg::POS_W;

	function automatic logic on_screen(input logic [SROW_W-1:0] r, input logic [SCOL_W-1:0] c);
		return (32'(r) < 32'(SCREEN_ROWS)) && (32'(c) < 32'(SCREEN_COLUMNS));
	endfunction

	// only meaningful for on-screen coordinates
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [SROW_W-1:0] r,
		input logic [SCOL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(c);
	endfunction

	// configuration
	logic [COL_W-1:0]           left_q  [2];
	logic [COL_W-1:0]           count_q [2];
	logic [wtc_pkg::ATTR_W-1:0] attr_q  [2];
	logic [ROW_W-1:0]           top_q;
	logic [ROW_W-1:0]           rows_q;

	// cursors and walk counters
	logic [COL_W-1:0]  col_q [2];
	logic [ROW_W-1:0]  row_q [2];
	logic [COL_W-1:0]  wx_q;
	logic [ROW_W-1:0]  wy_q;
	logic [ADDR_W-1:0] init_q;

	// captured item
	logic [wtc_pkg::ACT_W-1:0]  act_q;
	logic                       win_q;
	logic [wtc_pkg::CHAR_W-1:0] ch_q;
	logic [wtc_pkg::AIN_W-1:0]  addr_q;

	// screen memory
	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rdata_q;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;

	logic              res_valid_q;
	logic [POS_W-1:0]  res_cursor_q;
	logic [CELL_W-1:0] res_data_q;

	// selected window
	logic [COL_W-1:0]           left;
	logic [COL_W-1:0]           wd;
	logic [ROW_W-1:0]           ht;
	logic [wtc_pkg::ATTR_W-1:0] attr;
	logic [CELL_W-1:0]          blank;
	logic [COL_W-1:0]           col;
	logic [ROW_W-1:0]           row;
	logic [SROW_W-1:0]          cur_srow;
	logic                       addr_ok;

	// put
	logic [SCOL_W-1:0] ncol;
	logic [SROW_W-1:0] nrow;
	logic              put_we;
	logic [SCOL_W-1:0] put_col;
	logic [CELL_W-1:0] put_data;
	logic              put_scroll;

	// walk
	logic [SROW_W-1:0] src_row;
	logic [SROW_W-1:0] dst_row;
	logic [SCOL_W-1:0] wcol;
	logic              src_on;
	logic              wx_end;
	logic [CELL_W-1:0] scr_data;

	assign left     = left_q[win_q];
	assign wd       = (count_q[win_q] == '0) ? COL_W'(1) : count_q[win_q];
	assign ht       = (rows_q == '0) ? ROW_W'(1) : rows_q;
	assign attr     = attr_q[win_q];
	assign blank    = {attr, wtc_pkg::CH_SPACE};
	assign col      = col_q[win_q];
	assign row      = row_q[win_q];
	assign cur_srow = SROW_W'(top_q) + SROW_W'(row);
	assign addr_ok  = 32'(addr_q) < 32'(CELL_COUNT);

	always_comb begin
		ncol     = SCOL_W'(col);
		nrow     = SROW_W'(row);
		put_we   = 1'b0;
		put_col  = SCOL_W'(left) + SCOL_W'(col);
		put_data = {attr, ch_q};
		if (ch_q == wtc_pkg::CH_NL) begin
			ncol = '0;
			nrow = nrow + SROW_W'(1);
		end else if (ch_q == wtc_pkg::CH_CR) begin
			ncol = '0;
		end else if (ch_q == wtc_pkg::CH_BS) begin
			if (col != '0) begin
				ncol     = SCOL_W'(col) - SCOL_W'(1);
				put_we   = 1'b1;
				put_col  = SCOL_W'(left) + SCOL_W'(col) - SCOL_W'(1);
				put_data = blank;
			end
		end else if (!ch_q[wtc_pkg::CHAR_W-1] && (ch_q >= wtc_pkg::CH_SPACE)) begin
			put_we = 1'b1;
			ncol   = ncol + SCOL_W'(1);
		end
		// wrap at window width
		if (ncol >= SCOL_W'(wd)) begin
			ncol = '0;
			nrow = nrow + SROW_W'(1);
		end
		put_scroll = nrow >= SROW_W'(ht);
		if (put_scroll) begin
			nrow = SROW_W'(ht) - SROW_W'(1);
		end
	end

	// clear walks rows 0..ht-1; scroll walks rows 1..ht, the last one filled with blank
	assign src_row  = SROW_W'(top_q) + SROW_W'(wy_q);
	assign dst_row  = src_row - SROW_W'(1);
	assign wcol     = SCOL_W'(left) + SCOL_W'(wx_q);
	assign src_on   = on_screen(src_row, wcol) && (wy_q < ht);
	assign wx_end   = wx_q == (wd - COL_W'(1));
	assign scr_data = src_on ? rdata_q : blank;

	always_comb begin
		we    = 1'b0;
		waddr = init_q;
		wdata = wtc_pkg::RESET_CELL;
		if (cmd.init_write) begin
			we = 1'b1;
		end else if (cmd.put) begin
			we    = put_we && on_screen(cur_srow, put_col);
			waddr = cell_addr(cur_srow, put_col);
			wdata = put_data;
		end else if (cmd.clr_write) begin
			we    = on_screen(src_row, wcol);
			waddr = cell_addr(src_row, wcol);
			wdata = blank;
		end else if (cmd.scr_write) begin
			we    = on_screen(dst_row, wcol);
			waddr = cell_addr(dst_row, wcol);
			wdata = scr_data;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = ADDR_W'(addr_q);
		if (cmd.item_read) begin
			re = addr_ok;
		end else if (cmd.scr_read) begin
			re    = src_on;
			raddr = cell_addr(src_row, wcol);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q  <= item_action;
			win_q  <= item_window;
			ch_q   <= item_char;
			addr_q <= item_address;
		end
		if (cmd.out_load) begin
			res_cursor_q <= POS_W'(cur_srow) * POS_W'(SCREEN_COLUMNS)
				+ POS_W'(left) + POS_W'(col);
			res_data_q   <= ((act_q == wtc_pkg::ACT_READ) && addr_ok) ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q[0]   <= wtc_pkg::RST_LEFT_A;
			count_q[0]  <= wtc_pkg::RST_COUNT_A;
			left_q[1]   <= wtc_pkg::RST_LEFT_B;
			count_q[1]  <= wtc_pkg::RST_COUNT_B;
			top_q       <= wtc_pkg::RST_TOP;
			rows_q      <= wtc_pkg::RST_ROWS;
			attr_q[0]   <= wtc_pkg::RST_ATTR;
			attr_q[1]   <= wtc_pkg::RST_ATTR;
			col_q[0]    <= '0;
			col_q[1]    <= '0;
			row_q[0]    <= '0;
			row_q[1]    <= '0;
			wx_q        <= '0;
			wy_q        <= '0;
			init_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					wtc_pkg::REG_LEFT_A:  left_q[0]  <= cfg_data[COL_W-1:0];
					wtc_pkg::REG_COUNT_A: count_q[0] <= cfg_data[COL_W-1:0];
					wtc_pkg::REG_LEFT_B:  left_q[1]  <= cfg_data[COL_W-1:0];
					wtc_pkg::REG_COUNT_B: count_q[1] <= cfg_data[COL_W-1:0];
					wtc_pkg::REG_TOP:     top_q      <= cfg_data[ROW_W-1:0];
					wtc_pkg::REG_ROWS:    rows_q     <= cfg_data[ROW_W-1:0];
					wtc_pkg::REG_ATTR_A:  attr_q[0]  <= cfg_data;
					wtc_pkg::REG_ATTR_B:  attr_q[1]  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.init_write) begin
				init_q <= init_q + ADDR_W'(1);
			end
			if (cmd.put) begin
				col_q[win_q] <= ncol[COL_W-1:0];
				row_q[win_q] <= nrow[ROW_W-1:0];
			end else if (cmd.clr_start) begin
				col_q[win_q] <= '0;
				row_q[win_q] <= '0;
			end
			if (cmd.clr_start) begin
				wx_q <= '0;
				wy_q <= '0;
			end else if (cmd.scr_start) begin
				wx_q <= '0;
				wy_q <= ROW_W'(1);
			end else if (cmd.clr_write || cmd.scr_write) begin
				if (wx_end) begin
					wx_q <= '0;
					wy_q <= wy_q + ROW_W'(1);
				end else begin
					wx_q <= wx_q + COL_W'(1);
				end
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat            = '0;
		stat.init_last  = init_q == ADDR_W'(CELL_COUNT - 1);
		stat.action     = act_q;
		stat.put_scroll = put_scroll;
		stat.clr_last   = wx_end && (wy_q == (ht - ROW_W'(1)));
		stat.scr_last   = wx_end && (wy_q == ht);
		stat.out_free   = !res_valid_q || res_ready;
	end

	assign res_valid  = res_valid_q;
	assign res_cursor = res_cursor_q;
	assign res_data   = res_data_q;

endmodule

`default_nettype wire

// File: rtl/core/windowed_text_console.sv
// ----------------------------------------------------------------------------
// windowed_text_console
// Text screen with two windows: put character, clear window, read cell.
// ----------------------------------------------------------------------------
// After reset the screen memory is filled with blanks, one cell per cycle;
// item ready stays low meanwhile, configuration writes are taken at any
// time. An item that writes at most one cell (printable, newline, carriage
// return, backspace, read, unused action) passes through decode and result
// hand-off, back to back while results are taken. A clear writes one cell
// per cycle over width * height cells. A put that scrolls moves the window
// up a row cell by cell, each cell read and then rewritten through the
// single write port of the screen memory, the bottom row with blanks.
// Every transaction returns the selected window's linear cursor position.
`default_nettype none

module windowed_text_console #(
	parameter int SCREEN_COLUMNS = wtc_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = wtc_pkg::SCREEN_ROWS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	wtc_item_if.sink       item,
	wtc_result_if.source   result,
	wtc_cfg_if.sink        cfg
);

	wtc_pkg::cmd_t  cmd;
	wtc_pkg::stat_t stat;
	logic           item_ready;

	assign item.ready = item_ready;
	assign cfg.ready  = 1'b1;

	wtc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	wtc_datapath #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item_action  (item.action),
		.item_window  (item.window_select),
		.item_char    (item.char_code),
		.item_address (item.cell_address),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.res_cursor   (result.cursor_position),
		.res_data     (result.cell_data)
	);

endmodule

`default_nettype wire
